### rtl/bsr_pkg.sv
// Shared constants, codes and types for the bitmap flag set core.
// Used by the request channel interface and the top level.
`default_nettype none

package bsr_pkg;

    // Number of flags held; the word count and the address and count widths derive from it.
    localparam int NUM_BITS   = 65536;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;
    localparam int WORD_COUNT = (NUM_BITS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CNT_W      = $clog2(WORD_COUNT + 1);
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 16;
    localparam int REM_BITS   = NUM_BITS % WORD_W;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [BIT_W-1:0]  t_bitpos;
    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [IDX_W-1:0]  t_idx;

    localparam t_cmd CMD_TEST      = 3'd0;
    localparam t_cmd CMD_SET_BIT   = 3'd1;
    localparam t_cmd CMD_CLR_BIT   = 3'd2;
    localparam t_cmd CMD_SET_RANGE = 3'd3;
    localparam t_cmd CMD_CLR_RANGE = 3'd4;
    localparam t_cmd CMD_SET_ALL   = 3'd5;
    localparam t_cmd CMD_CHK_EMPTY = 3'd6;

    localparam t_word   FULL_WORD = '1;
    localparam t_bitpos BIT_MAX   = '1;
    // Flags that exist in the last word; the upper unused bits stay clear.
    localparam t_word   LAST_MASK = (REM_BITS == 0) ? FULL_WORD :
                                    t_word'((64'd1 << REM_BITS) - 64'd1);
    localparam logic [IDX_W:0] NUM_BITS_X = (IDX_W + 1)'(NUM_BITS);
    localparam t_addr   LAST_ADDR = t_addr'(WORD_COUNT - 1);
    localparam t_cnt    CNT_FULL  = t_cnt'(WORD_COUNT);

endpackage

`default_nettype wire

### rtl/bsr_req_if.sv
// Request channel of the bitmap flag set core: valid/ready plus command fields.
// Depends on bsr_pkg for the field widths.
`default_nettype none

interface bsr_req_if;
    import bsr_pkg::*;

    logic valid;
    logic ready;
    t_cmd cmd;
    t_idx bit_index;
    t_idx range_end;

    modport source (output valid, cmd, bit_index, range_end, input ready);
    modport sink   (input valid, cmd, bit_index, range_end, output ready);
endinterface

`default_nettype wire

### rtl/bsr_rsp_if.sv
// Response channel of the bitmap flag set core: valid/ready plus result flags.
// Stands alone; carries single-bit fields only.
`default_nettype none

interface bsr_rsp_if;
    logic valid;
    logic ready;
    logic present;
    logic empty_res;

    modport source (output valid, present, empty_res, input ready);
    modport sink   (input valid, present, empty_res, output ready);
endinterface

`default_nettype wire

### rtl/bitmap_set_with_range_ops_core.sv
// Top level of the bitmap flag set core: command decode, word walker and result register.
// Depends on bsr_pkg, bsr_req_if, bsr_rsp_if and bsr_ram.
`default_nettype none

// Channel   Dir  Handshake                  Payload
// i_req     in   valid/ready, edge if both  cmd, bit_index, range_end
// o_rsp     out  valid/ready, edge if both  present, empty_res
//
// Per item: test, set bit and clear bit read their word on acceptance and walk it;
// check empty needs no read. A range command walks every word it touches, and set
// all fills all WORD_COUNT words. The single read and single write port of the word
// RAM paces this: one word is read and one written per cycle, unless a full output
// register holds the last word. After reset a clearing pass writes zero to all
// WORD_COUNT words before the first item is accepted.
// A held result stalls only the end of the next item, not its acceptance.

module bitmap_set_with_range_ops_core (
    input wire logic i_clk,
    input wire logic i_rst_n,
    bsr_req_if.sink  i_req,
    bsr_rsp_if.source o_rsp
);
    import bsr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FILL,
        S_FIN
    } t_state;

    t_state  r_state;
    t_addr   r_w;         // current word of a walk or fill
    t_addr   r_w0;        // first word of the walk
    t_addr   r_w1;        // last word of the walk
    t_bitpos r_lo;        // low bit in the first word
    t_bitpos r_hi;        // high bit in the last word
    logic    r_op_set;    // walk sets flags (else clears)
    logic    r_op_write;  // walk writes (else it is a test)
    logic    r_fill_set;  // fill writes ones and reports a result
    t_cnt    r_cnt;       // number of nonzero words
    logic    r_fin_present;
    logic    r_fin_empty;
    logic    r_out_valid;
    logic    r_out_present;
    logic    r_out_empty;

    // Decode of the item on the request channel.
    logic    accept;
    logic    in_range;
    logic    range_ok;
    t_idx    last_idx;
    logic    is_single;
    logic    is_range;
    logic    is_write_cmd;

    // Word path.
    t_word   old_word;
    t_word   new_word;
    t_word   span;
    t_bitpos lo_bit;
    t_bitpos hi_bit;
    logic    walk_last;
    logic    fill_last;
    logic    slot_free;
    logic    walk_go;
    logic    fill_go;
    logic    load_out;
    t_cnt    n_cnt;

    // RAM controls.
    logic    ram_we;
    t_addr   ram_waddr;
    t_word   ram_wdata;
    logic    ram_re;
    t_addr   ram_raddr;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.present   = r_out_present;
    assign o_rsp.empty_res = r_out_empty;

    // A new result can be loaded when the output register is empty or drains now.
    assign slot_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        in_range     = {1'b0, i_req.bit_index} < NUM_BITS_X;
        range_ok     = ({1'b0, i_req.range_end} < NUM_BITS_X) &&
                       (i_req.range_end > i_req.bit_index);
        last_idx     = i_req.range_end - t_idx'(1);
        is_write_cmd = (i_req.cmd == CMD_SET_BIT) || (i_req.cmd == CMD_CLR_BIT);
        is_single    = in_range && ((i_req.cmd == CMD_TEST) || is_write_cmd);
        is_range     = range_ok &&
                       ((i_req.cmd == CMD_SET_RANGE) || (i_req.cmd == CMD_CLR_RANGE));
    end

    // Mask of the flags touched in the current word: partial at both ends of a
    // walk, full in the middle. A single-bit command is a walk of one bit.
    always_comb begin
        lo_bit    = (r_w == r_w0) ? r_lo : '0;
        hi_bit    = (r_w == r_w1) ? r_hi : BIT_MAX;
        span      = (FULL_WORD >> (BIT_MAX - hi_bit)) & (FULL_WORD << lo_bit);
        new_word  = r_op_set ? (old_word | span) : (old_word & ~span);
        walk_last = (r_w == r_w1);
        fill_last = (r_w == LAST_ADDR);
        walk_go   = (r_state == S_WALK) && (!walk_last || slot_free);
        fill_go   = (r_state == S_FILL) && (!fill_last || !r_fill_set || slot_free);
        n_cnt     = r_cnt + t_cnt'(new_word != '0) - t_cnt'(old_word != '0);
        // The output register takes a new result at the end of every item.
        load_out  = (walk_go && walk_last) ||
                    (fill_go && fill_last && r_fill_set) ||
                    ((r_state == S_FIN) && slot_free);
    end

    // The read of the first word of a walk is issued in the cycle the item is accepted;
    // during a walk the next word is read while the current one is written,
    // so reads and writes never meet at the same word.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_w + t_addr'(1);
        ram_we    = 1'b0;
        ram_waddr = r_w;
        ram_wdata = new_word;
        if (accept) begin
            ram_re    = is_single || is_range;
            ram_raddr = t_addr'(i_req.bit_index >> BIT_W);
        end else if (walk_go && !walk_last) begin
            ram_re = 1'b1;
        end
        if (walk_go && r_op_write) begin
            ram_we = 1'b1;
        end else if (fill_go) begin
            ram_we    = 1'b1;
            ram_wdata = !r_fill_set ? '0 : (fill_last ? LAST_MASK : FULL_WORD);
        end
    end

    bsr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORD_COUNT)
    ) u_words (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (old_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_w         <= '0;
            r_fill_set  <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op_set      <= (i_req.cmd == CMD_SET_BIT) ||
                                         (i_req.cmd == CMD_SET_RANGE);
                        r_op_write    <= (i_req.cmd != CMD_TEST);
                        r_fin_present <= (i_req.cmd == CMD_TEST);
                        r_fin_empty   <= (i_req.cmd == CMD_CHK_EMPTY) && (r_cnt == '0);
                        r_w0          <= t_addr'(i_req.bit_index >> BIT_W);
                        r_lo          <= i_req.bit_index[BIT_W-1:0];
                        if (is_range) begin
                            r_w     <= t_addr'(i_req.bit_index >> BIT_W);
                            r_w1    <= t_addr'(last_idx >> BIT_W);
                            r_hi    <= last_idx[BIT_W-1:0];
                            r_state <= S_WALK;
                        end else if (is_single) begin
                            r_w     <= t_addr'(i_req.bit_index >> BIT_W);
                            r_w1    <= t_addr'(i_req.bit_index >> BIT_W);
                            r_hi    <= i_req.bit_index[BIT_W-1:0];
                            r_state <= S_WALK;
                        end else if (i_req.cmd == CMD_SET_ALL) begin
                            r_w        <= '0;
                            r_fill_set <= 1'b1;
                            r_state    <= S_FILL;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_WALK: begin
                    if (walk_go) begin
                        if (r_op_write) begin
                            r_cnt <= n_cnt;
                        end
                        if (walk_last) begin
                            r_out_present <= !r_op_write && old_word[r_lo];
                            r_out_empty   <= 1'b0;
                            r_state       <= S_IDLE;
                        end else begin
                            r_w <= r_w + t_addr'(1);
                        end
                    end
                end
                S_FILL: begin
                    if (fill_go) begin
                        if (fill_last) begin
                            r_cnt   <= r_fill_set ? CNT_FULL : '0;
                            r_state <= S_IDLE;
                            if (r_fill_set) begin
                                r_out_present <= 1'b0;
                                r_out_empty   <= 1'b0;
                            end
                        end else begin
                            r_w <= r_w + t_addr'(1);
                        end
                    end
                end
                S_FIN: begin
                    if (slot_free) begin
                        r_out_present <= r_fin_present;
                        r_out_empty   <= r_fin_empty;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

### rtl/bsr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module bsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

### tb/tb_bitmap_set_with_range_ops_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap flag set core: a queue-fed driver, a
// checking monitor and an in-bench bitmap predictor. Depends on bsr_pkg,
// bsr_req_if, bsr_rsp_if and bitmap_set_with_range_ops_core.

module tb_bitmap_set_with_range_ops_core;
    import bsr_pkg::*;

    // The field encoding leaves code 7 unused; the core must answer it with zeros.
    localparam t_cmd CMD_UNUSED = 3'd7;

    localparam int IDX_MAX   = (1 << IDX_W) - 1;
    localparam int TAIL_BITS = NUM_BITS % WORD_W;
    localparam t_word TAIL_MASK = (TAIL_BITS == 0) ? '1 :
                                  t_word'((64'd1 << TAIL_BITS) - 64'd1);

    localparam int RANDOM_ITEMS    = 1500;
    localparam int MAX_IDLE        = 40;
    localparam int PRESSURE_AT     = 400;
    localparam int PRESSURE_CYCLES = 600;
    localparam int SETTLE_CYCLES   = 100;

    typedef struct {
        t_cmd cmd;
        t_idx bit_index;
        t_idx range_end;
    } t_flag_cmd;

    typedef struct {
        logic present;
        logic empty_res;
    } t_flag_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Driven copies of the channel inputs; every one is known from time zero.
    logic drv_valid = 1'b0;
    t_cmd drv_cmd = CMD_TEST;
    t_idx drv_index = '0;
    t_idx drv_end = '0;
    logic rcv_ready = 1'b1;

    bsr_req_if req_ch();
    bsr_rsp_if rsp_ch();

    assign req_ch.valid     = drv_valid;
    assign req_ch.cmd       = drv_cmd;
    assign req_ch.bit_index = drv_index;
    assign req_ch.range_end = drv_end;
    assign rsp_ch.ready     = rcv_ready;

    bitmap_set_with_range_ops_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Predicted contents of the flag words, updated as each item is accepted.
    t_word flag_words [WORD_COUNT];

    t_flag_cmd    cmd_backlog [$];
    t_flag_result awaited [$];
    t_flag_cmd    next_item;
    t_flag_result want;

    longint cycle_count = 0;
    longint cycle_limit = 64'd100_000_000;
    longint cycle_budget = 0;
    int     errors = 0;
    int     results_seen = 0;
    int     present_hits = 0;
    int     empty_hits = 0;
    int     per_cmd [8];
    bit     req_accepted = 1'b0;
    int     send_gap = 0;
    int     stall_left = 0;
    int     pressure_left = 0;
    bit     pressure_done = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Bits lo..hi inclusive of one word.
    function automatic t_word span_bits(int lo, int hi);
        t_word upper;
        t_word lower;
        upper = t_word'((64'd1 << (hi + 1)) - 64'd1);
        lower = t_word'((64'd1 << lo) - 64'd1);
        return upper & ~lower;
    endfunction

    // Applies one command to the predicted bitmap and returns the result it owes.
    function automatic t_flag_result run_command(t_flag_cmd c);
        t_flag_result r;
        int idx;
        int lim;
        int first_w;
        int last_w;
        bit in_map;
        bit span_ok;
        t_word mask;
        r.present = 1'b0;
        r.empty_res = 1'b0;
        idx = int'(c.bit_index);
        lim = int'(c.range_end);
        in_map = idx < NUM_BITS;
        span_ok = (lim < NUM_BITS) && (lim > idx);
        case (c.cmd)
            CMD_TEST: begin
                r.present = in_map ? flag_words[idx / WORD_W][idx % WORD_W] : 1'b1;
            end
            CMD_SET_BIT: begin
                if (in_map) flag_words[idx / WORD_W][idx % WORD_W] = 1'b1;
            end
            CMD_CLR_BIT: begin
                if (in_map) flag_words[idx / WORD_W][idx % WORD_W] = 1'b0;
            end
            CMD_SET_RANGE, CMD_CLR_RANGE: begin
                if (span_ok) begin
                    first_w = idx / WORD_W;
                    last_w = (lim - 1) / WORD_W;
                    for (int w = first_w; w <= last_w && w < WORD_COUNT; w++) begin
                        mask = span_bits((w == first_w) ? idx % WORD_W : 0,
                                         (w == last_w) ? (lim - 1) % WORD_W : WORD_W - 1);
                        if (c.cmd == CMD_SET_RANGE) flag_words[w] |= mask;
                        else flag_words[w] &= ~mask;
                    end
                end
            end
            CMD_SET_ALL: begin
                for (int w = 0; w < WORD_COUNT; w++) flag_words[w] = '1;
                flag_words[WORD_COUNT - 1] = TAIL_MASK;
            end
            CMD_CHK_EMPTY: begin
                r.empty_res = 1'b1;
                for (int w = 0; w < WORD_COUNT; w++)
                    if (flag_words[w] != '0) r.empty_res = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Queues one item and adds its worst-case cost to the cycle budget.
    function automatic void queue_cmd(t_cmd c, int idx, int lim);
        t_flag_cmd item;
        int words;
        item.cmd = c;
        item.bit_index = t_idx'(idx);
        item.range_end = t_idx'(lim);
        cmd_backlog.push_back(item);
        words = 1;
        if (c == CMD_SET_ALL)
            words = WORD_COUNT;
        else if ((c == CMD_SET_RANGE || c == CMD_CLR_RANGE) && lim > idx)
            words = (lim - 1) / WORD_W - idx / WORD_W + 1;
        cycle_budget += words + 2 + 2 * MAX_IDLE;
    endfunction

    function automatic int any_index();
        return $urandom_range(IDX_MAX, 0);
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int draw_idle();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 85) return $urandom_range(3, 1);
        if (pick < 97) return $urandom_range(12, 4);
        return $urandom_range(MAX_IDLE, 20);
    endfunction

    // Every third stretch of 128 results runs with no idling on either side.
    function automatic bit calm_phase();
        return ((results_seen / 128) % 3) == 2;
    endfunction

    // Fill everything, poke at it, then wipe the whole map so that the empty
    // check can come back true again.
    function automatic void fill_and_wipe();
        int s;
        queue_cmd(CMD_SET_ALL, any_index(), any_index());
        repeat (3) queue_cmd(CMD_TEST, any_index(), any_index());
        repeat (2) begin
            s = $urandom_range(IDX_MAX - 1, 0);
            queue_cmd(CMD_CLR_RANGE, s, $urandom_range(s + 40 > IDX_MAX ? IDX_MAX : s + 40,
                                                       s + 1));
        end
        queue_cmd(CMD_CHK_EMPTY, any_index(), any_index());
        queue_cmd(CMD_CLR_RANGE, 0, IDX_MAX);
        queue_cmd(CMD_TEST, IDX_MAX, any_index());
        queue_cmd(CMD_CLR_BIT, IDX_MAX, any_index());
        queue_cmd(CMD_CHK_EMPTY, any_index(), any_index());
    endfunction

    // A burst of commands aimed at one window of flags, so that sets, clears
    // and tests actually meet. Most windows are cleaned up at the end.
    function automatic void window_burst();
        int lo;
        int hi;
        int span;
        int pick;
        int s;
        int e;
        pick = $urandom_range(99, 0);
        if (pick < 15) lo = $urandom_range(64, 0);
        else if (pick < 30) lo = $urandom_range(IDX_MAX, IDX_MAX - 64);
        else lo = any_index();
        pick = $urandom_range(99, 0);
        if (pick < 85) span = $urandom_range(96, 1);
        else if (pick < 97) span = $urandom_range(2000, 97);
        else span = $urandom_range(IDX_MAX, 2001);
        hi = (lo + span > IDX_MAX) ? IDX_MAX : lo + span;
        if (hi == lo) lo = hi - 1;
        repeat ($urandom_range(30, 10)) begin
            pick = $urandom_range(99, 0);
            s = $urandom_range(hi, lo);
            e = (s < hi) ? $urandom_range(hi, s + 1) : hi;
            if (pick < 30) queue_cmd(CMD_TEST, s, any_index());
            else if (pick < 50) queue_cmd(CMD_SET_BIT, s, any_index());
            else if (pick < 65) queue_cmd(CMD_CLR_BIT, s, any_index());
            else if (pick < 77) queue_cmd(CMD_SET_RANGE, s, e);
            else if (pick < 87) queue_cmd(CMD_CLR_RANGE, s, e);
            else if (pick < 94) queue_cmd(CMD_CHK_EMPTY, any_index(), any_index());
            else if (pick < 97)
                // Backwards or empty range: must leave the map alone.
                queue_cmd($urandom_range(1, 0) ? CMD_SET_RANGE : CMD_CLR_RANGE,
                          s, $urandom_range(s, 0));
            else queue_cmd(CMD_UNUSED, any_index(), any_index());
        end
        if ($urandom_range(99, 0) < 80) begin
            queue_cmd(CMD_CLR_RANGE, lo, hi);
            queue_cmd(CMD_CLR_BIT, hi, any_index());
            queue_cmd(CMD_CHK_EMPTY, any_index(), any_index());
        end
    endfunction

    // Stimulus, reset and the end of the run.
    initial begin
        int directed_count;
        for (int w = 0; w < WORD_COUNT; w++) flag_words[w] = '0;
        for (int k = 0; k < 8; k++) per_cmd[k] = 0;

        // Directed part: a fresh map is empty and reads zero at both ends.
        queue_cmd(CMD_CHK_EMPTY, 0, 0);
        queue_cmd(CMD_TEST, 0, IDX_MAX);
        queue_cmd(CMD_TEST, IDX_MAX, 0);
        // Lowest and highest flag, set then cleared again.
        queue_cmd(CMD_SET_BIT, 0, 0);
        queue_cmd(CMD_SET_BIT, IDX_MAX, IDX_MAX);
        queue_cmd(CMD_TEST, IDX_MAX, 0);
        queue_cmd(CMD_CHK_EMPTY, IDX_MAX, IDX_MAX);
        queue_cmd(CMD_CLR_BIT, 0, 0);
        queue_cmd(CMD_CLR_BIT, IDX_MAX, 0);
        queue_cmd(CMD_CHK_EMPTY, 0, IDX_MAX);
        // Empty and backwards ranges are refused.
        queue_cmd(CMD_SET_RANGE, 5, 5);
        queue_cmd(CMD_SET_RANGE, IDX_MAX, 0);
        queue_cmd(CMD_CHK_EMPTY, 0, 0);
        // Partial first word, one full middle word, partial last word; then
        // a range inside one word and a range of exactly one whole word.
        queue_cmd(CMD_SET_RANGE, 3, 70);
        queue_cmd(CMD_TEST, 2, 0);
        queue_cmd(CMD_TEST, 69, 0);
        queue_cmd(CMD_TEST, 70, 0);
        queue_cmd(CMD_CLR_RANGE, 40, 45);
        queue_cmd(CMD_SET_RANGE, 96, 128);
        // Full-map sweeps; the top flag is out of reach of any range.
        queue_cmd(CMD_CLR_RANGE, 0, IDX_MAX);
        queue_cmd(CMD_SET_ALL, IDX_MAX, IDX_MAX);
        queue_cmd(CMD_CLR_RANGE, 0, IDX_MAX);
        queue_cmd(CMD_TEST, IDX_MAX, 0);
        queue_cmd(CMD_CLR_BIT, IDX_MAX, 0);
        queue_cmd(CMD_UNUSED, IDX_MAX, IDX_MAX);
        queue_cmd(CMD_CHK_EMPTY, IDX_MAX, 0);
        directed_count = cmd_backlog.size();

        while (cmd_backlog.size() < directed_count + RANDOM_ITEMS) begin
            if ($urandom_range(99, 0) < 6) fill_and_wipe();
            else window_burst();
        end

        // Every item at its worst, plus the clearing pass after reset and the
        // long hold-off, taken four times over.
        cycle_limit = 4 * (cycle_budget + 2 * WORD_COUNT + PRESSURE_CYCLES) + 1000;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || drv_valid) @(posedge i_clk);
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (awaited.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, awaited.size());
        end
        $display("Checked %0d results: %0d tests (%0d present), %0d empty checks (%0d empty).",
                 results_seen, per_cmd[CMD_TEST], present_hits, per_cmd[CMD_CHK_EMPTY],
                 empty_hits);
        $display({"Writes: %0d bit sets, %0d bit clears, %0d range sets, %0d range clears, ",
                  "%0d set-alls, %0d unused codes; %0d errors."},
                 per_cmd[CMD_SET_BIT], per_cmd[CMD_CLR_BIT], per_cmd[CMD_SET_RANGE],
                 per_cmd[CMD_CLR_RANGE], per_cmd[CMD_SET_ALL], per_cmd[CMD_UNUSED], errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Sampling at the rising edge: accepted items feed the predictor, accepted
    // results are checked against the oldest prediction.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > cycle_limit) begin
            $display("%0t: timeout after %0d cycles, %0d results still expected",
                     $time, cycle_count, awaited.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            req_accepted = 1'b0;
            if (i_rst_n && req_ch.valid && req_ch.ready) begin
                req_accepted = 1'b1;
                next_item.cmd = req_ch.cmd;
                next_item.bit_index = req_ch.bit_index;
                next_item.range_end = req_ch.range_end;
                per_cmd[req_ch.cmd]++;
                want = run_command(next_item);
                present_hits += want.present;
                empty_hits += want.empty_res;
                awaited.push_back(want);
            end
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                results_seen++;
                if (awaited.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: present=%b empty_res=%b",
                             $time, rsp_ch.present, rsp_ch.empty_res);
                end else begin
                    want = awaited.pop_front();
                    if (rsp_ch.present !== want.present) begin
                        errors++;
                        $display("%0t: present mismatch: expected %b, got %b",
                                 $time, want.present, rsp_ch.present);
                    end
                    if (rsp_ch.empty_res !== want.empty_res) begin
                        errors++;
                        $display("%0t: empty_res mismatch: expected %b, got %b",
                                 $time, want.empty_res, rsp_ch.empty_res);
                    end
                end
            end
        end
    end

    // Driver: a new item goes out at the falling edge once the previous one
    // was taken, after an optional random gap.
    always @(negedge i_clk) begin
        if (i_rst_n && (req_accepted || !drv_valid)) begin
            if (send_gap > 0) begin
                send_gap--;
                drv_valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                next_item = cmd_backlog.pop_front();
                drv_cmd <= next_item.cmd;
                drv_index <= next_item.bit_index;
                drv_end <= next_item.range_end;
                drv_valid <= 1'b1;
                send_gap = (!calm_phase() && $urandom_range(99, 0) < 30) ? draw_idle() : 0;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, and once a long hold-off while the driver keeps
    // offering items, so the core backs up and drops its input ready.
    always @(negedge i_clk) begin
        if (!pressure_done && results_seen >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            pressure_left = PRESSURE_CYCLES;
        end
        if (pressure_left > 0) begin
            pressure_left--;
            rcv_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rcv_ready <= 1'b0;
        end else if (!calm_phase() && $urandom_range(99, 0) < 12) begin
            stall_left = draw_idle() - 1;
            rcv_ready <= 1'b0;
        end else begin
            rcv_ready <= 1'b1;
        end
    end

endmodule

### files.f
rtl/bsr_pkg.sv
rtl/bsr_req_if.sv
rtl/bsr_rsp_if.sv
rtl/bsr_ram.sv
rtl/bitmap_set_with_range_ops_core.sv
tb/tb_bitmap_set_with_range_ops_core.sv
